@@ hdl/psfd_pkg.sv @@
`default_nettype none

package psfd_pkg;

   localparam int FRAME_BITS = 40;
   localparam int FRAME_BYTES = 5;

   localparam int CMD_W = 2;
   localparam int TIME_W = 32;
   localparam int THR_W = 16;
   localparam int EDGES_W = 8;
   localparam int STATUS_W = 2;
   localparam int RAW_W = 16;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_FIELDS_W = STATUS_W + 2 * RAW_W + EDGES_W + 1;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd110;
   localparam logic [EDGES_W-1:0] REQUIRED_RESET = 8'd42;
   localparam logic [EDGES_W-1:0] EDGE_COUNT_MAX = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_START  = 2'd0,
      CMD_EDGE   = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK  = 2'd0,
      ST_FEW = 2'd1,
      ST_SUM = 2'd2,
      ST_RSV = 2'd3
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BIT_THRESHOLD  = 1'b0,
      CSR_REQUIRED_EDGES = 1'b1
   } csr_addr_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic                 count_warning;
      logic [EDGES_W-1:0]   edge_total;
      logic [RAW_W-1:0]     temperature_raw;
      logic [RAW_W-1:0]     humidity_raw;
      status_type           status;
   } rsp_type;

   // Byte k of the frame sits at bit 8*(4-k); bytes above the window read as 0.
   function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] win,
                                             input int k);
      logic [63:0] wide;
      int pos;
      wide = 64'(win);
      pos = 8 * (FRAME_BYTES - 1 - k);
      if (pos + 8 > FRAME_BITS) begin
         return 8'd0;
      end
      return wide[pos +: 8];
   endfunction

endpackage

`default_nettype wire

@@ hdl/pulse_interval_sensor_frame_decoder.sv @@
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: cmd; tdata: edge_time_us
// rsp      out  rsp_tvalid/rsp_tready  tdata: status, humidity, temperature, count, warning
// csr      in   csr_we                 csr_addr selects register, csr_wdata
//
// One transaction per cycle while req_tready is high. Start and edge update the state
// in the accept cycle; finish registers its report from the state into the output or skid.
// Output register plus one skid entry: req_tready drops only while the skid holds a result.
// Reset (sync) restores CSR defaults, clears count, timestamp, window, output and skid.

module pulse_interval_sensor_frame_decoder (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [psfd_pkg::REQ_TDATA_W-1:0]      req_tdata,  // [31:0] edge_time_us
   input  wire  [psfd_pkg::REQ_TUSER_W-1:0]      req_tuser,  // [1:0] cmd
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // [1:0] status, [17:2] humidity_raw, [33:18] temperature_raw,
   // [41:34] edge_total, [42] count_warning, [47:43] zero
   output logic [psfd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire                                   csr_we,
   input  wire  [psfd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire  [psfd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import psfd_pkg::*;

   logic [THR_W-1:0]      threshold_ff;
   logic [EDGES_W-1:0]    required_ff;
   logic [EDGES_W-1:0]    edge_count_ff, edge_count_in;
   logic [TIME_W-1:0]     prev_time_ff, prev_time_in;
   logic [FRAME_BITS-1:0] window_ff, window_in;

   logic                  out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [RSP_TDATA_W-1:0] skid_ff, skid_in;

   cmd_type               cmd;
   logic [TIME_W-1:0]     edge_time;
   logic [TIME_W-1:0]     interval;
   logic                  new_bit;
   logic                  accept;
   logic                  push;
   logic                  pop;
   logic [7:0]            b0, b1, b2, b3, b4;
   logic [7:0]            sum;
   rsp_type               result;

   assign cmd       = cmd_type'(req_tuser);
   assign edge_time = req_tdata[TIME_W-1:0];
   assign accept    = req_tvalid && req_tready;
   assign push      = accept && (cmd == CMD_FINISH);
   assign pop       = out_valid_ff && rsp_tready;

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   assign interval = edge_time - prev_time_ff;
   assign new_bit  = interval > TIME_W'(threshold_ff);

   always_comb begin
      edge_count_in = edge_count_ff;
      prev_time_in  = prev_time_ff;
      window_in     = window_ff;
      if (accept) begin
         case (cmd)
            CMD_START: begin
               edge_count_in = '0;
            end
            CMD_EDGE: begin
               window_in    = {window_ff[FRAME_BITS-2:0], new_bit};
               prev_time_in = edge_time;
               if (edge_count_ff != EDGE_COUNT_MAX) begin
                  edge_count_in = edge_count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign b0  = frame_byte(window_ff, 0);
   assign b1  = frame_byte(window_ff, 1);
   assign b2  = frame_byte(window_ff, 2);
   assign b3  = frame_byte(window_ff, 3);
   assign b4  = frame_byte(window_ff, 4);
   assign sum = b0 + b1 + b2 + b3;

   always_comb begin
      result = '0;
      result.edge_total = edge_count_ff;
      if (edge_count_ff < required_ff) begin
         result.status = ST_FEW;
      end else begin
         result.count_warning = (edge_count_ff != required_ff);
         if (sum != b4) begin
            result.status = ST_SUM;
         end else begin
            result.status          = ST_OK;
            result.humidity_raw    = {b0, b1};
            result.temperature_raw = {b2, b3};
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = RSP_TDATA_W'(result);
            out_valid_in = 1'b1;
         end else begin
            skid_in       = RSP_TDATA_W'(result);
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         required_ff   <= REQUIRED_RESET;
         edge_count_ff <= '0;
         prev_time_ff  <= '0;
         window_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr_type'(csr_addr))
               CSR_BIT_THRESHOLD:  threshold_ff <= csr_wdata[THR_W-1:0];
               CSR_REQUIRED_EDGES: required_ff  <= csr_wdata[EDGES_W-1:0];
               default: begin
               end
            endcase
         end
         edge_count_ff <= edge_count_in;
         prev_time_ff  <= prev_time_in;
         window_ff     <= window_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

@@ tb/psfd_checker.sv @@
`timescale 1ns / 1ps

module psfd_checker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   input  wire                                   req_tready,
   input  wire  [psfd_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire  [psfd_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  wire                                   rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire  [psfd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire                                   csr_we,
   input  wire  [psfd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire  [psfd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                    pending_reports,
   output int                                    mismatch_count
);
   import psfd_pkg::*;

   localparam int HUM_LSB = STATUS_W;
   localparam int TEMP_LSB = HUM_LSB + RAW_W;
   localparam int TOTAL_LSB = TEMP_LSB + RAW_W;
   localparam int WARN_BIT = TOTAL_LSB + EDGES_W;

   typedef struct {
      status_type          status;
      logic [RAW_W-1:0]    humidity;
      logic [RAW_W-1:0]    temperature;
      logic [EDGES_W-1:0]  edge_total;
      logic                warning;
   } sensor_report_type;

   sensor_report_type      expected_reports[$];
   logic [THR_W-1:0]       threshold_us;
   logic [EDGES_W-1:0]     edges_needed;
   logic [EDGES_W-1:0]     edges_seen;
   logic [TIME_W-1:0]      last_edge_us;
   logic [FRAME_BITS-1:0]  interval_bits;
   int                     errors = 0;

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
   endtask

   // byte k of the frame, oldest byte first; checksum is byte 4
   function automatic logic [7:0] window_byte(input int k);
      int pos;
      pos = 8 * (FRAME_BYTES - 1 - k);
      if (pos + 8 > FRAME_BITS) begin
         return 8'd0;
      end
      return interval_bits[pos +: 8];
   endfunction

   task automatic predict_request(input cmd_type cmd, input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] interval;
      logic [7:0]        sum;
      sensor_report_type rpt;
      case (cmd)
         CMD_START: begin
            edges_seen = '0;
         end
         CMD_EDGE: begin
            interval = stamp - last_edge_us;
            interval_bits = {interval_bits[FRAME_BITS-2:0], interval > TIME_W'(threshold_us)};
            last_edge_us = stamp;
            if (edges_seen != EDGE_COUNT_MAX) begin
               edges_seen++;
            end
         end
         CMD_FINISH: begin
            rpt.status = ST_OK;
            rpt.humidity = '0;
            rpt.temperature = '0;
            rpt.edge_total = edges_seen;
            rpt.warning = 1'b0;
            if (edges_seen < edges_needed) begin
               rpt.status = ST_FEW;
            end else begin
               sum = window_byte(0) + window_byte(1) + window_byte(2) + window_byte(3);
               rpt.warning = (edges_seen != edges_needed);
               if (sum != window_byte(4)) begin
                  rpt.status = ST_SUM;
               end else begin
                  rpt.humidity = {window_byte(0), window_byte(1)};
                  rpt.temperature = {window_byte(2), window_byte(3)};
               end
            end
            expected_reports.push_back(rpt);
         end
         default: ;
      endcase
   endtask

   task automatic check_report(input logic [RSP_TDATA_W-1:0] data);
      sensor_report_type rpt;
      if (expected_reports.size() == 0) begin
         report_mismatch("unexpected report", '0, 64'(data));
      end else begin
         rpt = expected_reports.pop_front();
         if (data[STATUS_W-1:0] != rpt.status)
            report_mismatch("status", 64'(rpt.status), 64'(data[STATUS_W-1:0]));
         if (data[HUM_LSB +: RAW_W] != rpt.humidity)
            report_mismatch("humidity_raw", 64'(rpt.humidity), 64'(data[HUM_LSB +: RAW_W]));
         if (data[TEMP_LSB +: RAW_W] != rpt.temperature)
            report_mismatch("temperature_raw", 64'(rpt.temperature),
                            64'(data[TEMP_LSB +: RAW_W]));
         if (data[TOTAL_LSB +: EDGES_W] != rpt.edge_total)
            report_mismatch("edge_total", 64'(rpt.edge_total),
                            64'(data[TOTAL_LSB +: EDGES_W]));
         if (data[WARN_BIT] != rpt.warning)
            report_mismatch("count_warning", 64'(rpt.warning), 64'(data[WARN_BIT]));
         if (data[RSP_TDATA_W-1:WARN_BIT+1] != '0)
            report_mismatch("tdata padding", '0, 64'(data[RSP_TDATA_W-1:WARN_BIT+1]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold_us = THRESHOLD_RESET;
         edges_needed = REQUIRED_RESET;
         edges_seen = '0;
         last_edge_us = '0;
         interval_bits = '0;
      end else begin
         if (csr_we) begin
            case (csr_addr_type'(csr_addr))
               CSR_BIT_THRESHOLD:  threshold_us = csr_wdata[THR_W-1:0];
               CSR_REQUIRED_EDGES: edges_needed = csr_wdata[EDGES_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_request(cmd_type'(req_tuser), req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_report(rsp_tdata);
         end
      end
      pending_reports <= expected_reports.size();
      mismatch_count <= errors;
   end

endmodule

@@ tb/tb_pulse_interval_sensor_frame_decoder.sv @@
`timescale 1ns / 1ps

module tb_pulse_interval_sensor_frame_decoder;
   import psfd_pkg::*;

   localparam int ITEMS_PER_PHASE = 280;
   localparam int PHASES = 6;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int                      pending_reports;
   int                      mismatch_count;
   int                      tx_idle_pct = 7;
   int                      rx_idle_pct = 77;
   bit                      quiet = 1'b0;
   int                      items_sent = 0;
   logic [TIME_W-1:0]       stamp_us = '0;
   logic [THR_W-1:0]        threshold_now = THRESHOLD_RESET;
   logic [EDGES_W-1:0]      needed_now = REQUIRED_RESET;

   pulse_interval_sensor_frame_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   psfd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .pending_reports (pending_reports),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= rx_idle_pct);
   end

   task automatic send_item(input cmd_type cmd, input logic [TIME_W-1:0] data);
      while (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // wait until every report is out, then let the pipe settle before touching registers
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_reports != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] thr,
                                 input logic [CSR_DATA_W-1:0] need);
      csr_we <= 1'b1;
      csr_addr <= CSR_BIT_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_addr <= CSR_REQUIRED_EDGES;
      csr_wdata <= need;
      @(posedge clock);
      csr_we <= 1'b0;
      threshold_now = thr;
      needed_now = need[EDGES_W-1:0];
   endtask

   task automatic send_edge_bit(input bit one);
      logic [TIME_W-1:0] interval;
      if (one) begin
         case ($urandom_range(0, 7))
            0:       interval = TIME_W'(threshold_now) + 1;
            1:       interval = $urandom_range(32'hFFFF_FFFF, TIME_W'(threshold_now) + 1);
            default: interval = TIME_W'(threshold_now) + 1 + $urandom_range(0, 150);
         endcase
      end else if ($urandom_range(0, 3) == 0) begin
         interval = TIME_W'(threshold_now);
      end else begin
         interval = $urandom_range(0, threshold_now);
      end
      stamp_us += interval;
      send_item(CMD_EDGE, stamp_us);
   endtask

   task automatic run_frame();
      int                kind;
      int                n;
      int                i;
      bit                noisy;
      logic [7:0]        b0, b1, b2, b3, sum;
      logic [39:0]       frame;
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
         stamp_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end
      kind = $urandom_range(0, 99);
      if (kind >= 37 && kind < 45) begin
         // broken sequence: random commands, random stamps
         repeat ($urandom_range(4, 12)) begin
            send_item(cmd_type'($urandom_range(0, 3)), $urandom);
         end
      end else begin
         b0 = 8'($urandom);
         b1 = 8'($urandom);
         b2 = 8'($urandom);
         b3 = 8'($urandom);
         sum = b0 + b1 + b2 + b3;
         n = int'(needed_now);
         noisy = (kind >= 90);
         if (kind < 12) begin
            sum ^= 8'($urandom_range(1, 255));
         end else if (kind < 24) begin
            n = int'(needed_now) + $urandom_range(1, 6);
         end else if (kind < 34) begin
            n = (needed_now == 0) ? 0 : $urandom_range(0, int'(needed_now) - 1);
         end else if (kind < 37) begin
            n = $urandom_range(256, 290);
         end
         frame = {b0, b1, b2, b3, sum};
         send_item(CMD_START, $urandom);
         for (i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
               send_item(CMD_UNUSED, $urandom);
            end
            send_edge_bit((n - 1 - i < 40) ? frame[n - 1 - i] : 1'($urandom_range(0, 1)));
         end
         send_item(CMD_FINISH, $urandom);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] thr_set [PHASES];
      logic [CSR_DATA_W-1:0] need_set [PHASES];
      int                    p;
      thr_set = '{16'd110, 16'd0, 16'hFFFF, 16'($urandom_range(1, 2000)),
                  16'($urandom), 16'd110};
      need_set = '{16'd42, 16'd41, 16'd255, 16'd40,
                   {8'($urandom), 8'($urandom_range(41, 255))}, 16'd0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty finish, unused command, timestamp extremes and wrap,
      // threshold boundary, start clearing only the count
      send_item(CMD_FINISH, '0);
      send_item(CMD_UNUSED, '1);
      send_item(CMD_EDGE, 32'h0000_0000);
      send_item(CMD_EDGE, 32'hFFFF_FFFF);
      send_item(CMD_EDGE, 32'h0000_0000);
      send_item(CMD_EDGE, 32'd111);
      send_item(CMD_EDGE, 32'd221);
      send_item(CMD_FINISH, 32'h5555_5555);
      send_item(CMD_START, 32'hAAAA_AAAA);
      send_item(CMD_UNUSED, 32'h0000_0000);
      send_item(CMD_FINISH, '1);
      stamp_us = 32'd221;

      for (p = 0; p < PHASES; p++) begin
         case (p / 2)
            0:       begin tx_idle_pct = 7;  rx_idle_pct = 77; end
            1:       begin tx_idle_pct = 77; rx_idle_pct = 7;  end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         if (p > 0) begin
            drain_reports();
            write_settings(thr_set[p], need_set[p]);
         end
         while (items_sent < (p + 1) * ITEMS_PER_PHASE) begin
            run_frame();
         end
      end

      quiet = 1'b0;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_reports != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_reports == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
